/* hw/rtl/cii_pkg.sv */
// cii_pkg: shared types, constants and codes for the curve inverse interpolator
// depends on nothing
`timescale 1ns / 1ps

package cii_pkg;

    localparam int MAX_KEYS_DEFAULT = 64;
    localparam int CMD_FIFO_DEPTH   = 2;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [1:0] STATUS_INTERP   = 2'd0;
    localparam logic [1:0] STATUS_CLAMP_HI = 2'd1;
    localparam logic [1:0] STATUS_CLAMP_LO = 2'd2;
    localparam logic [1:0] STATUS_FEW_KEYS = 2'd3;

    // classified query handed from front to back
    typedef struct packed {
        logic               few;
        logic signed [31:0] distance;
    } query_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DECIDE,
        ST_CLAMP_LO,
        ST_FIND,
        ST_SEG_RD,
        ST_SEG_LATCH,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } eng_state_t;

endpackage

/* hw/rtl/curve_inverse_interpolator.sv */
// curve_inverse_interpolator: top level, front queue, engine and result register
// depends on cii_pkg, cii_front, cii_engine
//
//  channel   signals                                         direction
//  items     push full op key_index key_time key_value      in
//            query_distance
//  results   empty pop start_time status                     out
//  config    cfg_valid cfg_ready cfg_data (key_count)        in
//
//  loads are written as the front accepts them but wait while a query is queued or being processed
//  queries are queued two deep
//  a query runs a min/max scan over the value memory read port, a segment search
//  and then a shift-subtract divider
//  reset clears control; the key memories hold nothing until loaded
//  the engine result is held until pop, while queries keep queuing
`timescale 1ns / 1ps

module curve_inverse_interpolator #(
    parameter int MAX_KEYS = cii_pkg::MAX_KEYS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               op,
    input  logic [5:0]         key_index,
    input  logic signed [31:0] key_time,
    input  logic signed [31:0] key_value,
    input  logic signed [31:0] query_distance,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] start_time,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data
);
    import cii_pkg::*;

    localparam int IW = $clog2(MAX_KEYS);

    logic [6:0]    key_count_reg;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_time, wr_value;
    logic          cmd_valid, cmd_take;
    query_cmd_t    cmd;
    logic          res_valid;
    logic          eng_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            key_count_reg <= cfg_data;
    end

    cii_front #(.MAX_KEYS(MAX_KEYS), .IW(IW)) u_front (
        .clk, .rst_n, .push, .full, .op, .key_index, .key_time, .key_value,
        .query_distance,
        .key_count (key_count_reg),
        .eng_busy,
        .wr_en, .wr_addr, .wr_time, .wr_value,
        .cmd_valid, .cmd, .cmd_take
    );

    cii_engine #(.MAX_KEYS(MAX_KEYS), .IW(IW)) u_engine (
        .clk, .rst_n, .wr_en, .wr_addr, .wr_time, .wr_value,
        .key_count (key_count_reg),
        .cmd_valid, .cmd, .cmd_take,
        .busy      (eng_busy),
        .res_valid,
        .res_time   (start_time),
        .res_status (status),
        .res_take   (pop)
    );

    assign empty = !res_valid;

`ifndef SYNTHESIS
    // a query never enters the engine while a result waits
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> empty) else $error("query taken with result pending");
    // an undelivered result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(start_time) && $stable(status)))
        else $error("result changed before pop");
`endif

endmodule

/* hw/rtl/cii_front.sv */
// cii_front: accepts items, writes loads into the key memories, queues queries
// depends on cii_pkg
`timescale 1ns / 1ps

module cii_front #(
    parameter int MAX_KEYS = cii_pkg::MAX_KEYS_DEFAULT,
    parameter int IW       = $clog2(MAX_KEYS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     op,
    input  logic [5:0]               key_index,
    input  logic signed [31:0]       key_time,
    input  logic signed [31:0]       key_value,
    input  logic signed [31:0]       query_distance,
    input  logic [6:0]               key_count,
    input  logic                     eng_busy,
    output logic                     wr_en,
    output logic [IW-1:0]            wr_addr,
    output logic [31:0]              wr_time,
    output logic [31:0]              wr_value,
    output logic                     cmd_valid,
    output cii_pkg::query_cmd_t      cmd,
    input  logic                     cmd_take
);
    import cii_pkg::*;

    localparam int DW = $clog2(CMD_FIFO_DEPTH + 1);
    localparam int PW = $clog2(CMD_FIFO_DEPTH);

    query_cmd_t      fifo_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [DW-1:0]   cnt_reg, cnt_next;
    logic            acc, q_push;
    logic [10:0]     nk;
    query_cmd_t      new_cmd;

    // a load waits until no query is ahead of it in the queue or the engine
    assign full = (cnt_reg == DW'(CMD_FIFO_DEPTH)) ||
                  ((op == OP_LOAD) && (cmd_valid || eng_busy));
    assign acc  = push && !full;

    // index beyond the table is dropped
    assign wr_en    = acc && (op == OP_LOAD) && (32'(key_index) < MAX_KEYS);
    assign wr_addr  = IW'(key_index);
    assign wr_time  = key_time;
    assign wr_value = key_value;

    assign nk            = (32'(key_count) > MAX_KEYS) ? 11'(MAX_KEYS) : 11'(key_count);
    assign new_cmd.few      = (nk < 11'd2);
    assign new_cmd.distance = query_distance;
    assign q_push        = acc && (op == OP_QUERY);

    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == CMD_FIFO_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_take && cmd_valid)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == CMD_FIFO_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_push && !(cmd_take && cmd_valid))
            cnt_next = cnt_reg + 1'b1;
        else if (!q_push && cmd_take && cmd_valid)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            fifo_reg[wr_ptr_reg] <= new_cmd;
    end

endmodule

/* hw/rtl/cii_divider.sv */
// cii_divider: iterative signed 49-bit by 33-bit division, one quotient bit per cycle
// depends on cii_pkg
`timescale 1ns / 1ps

module cii_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [48:0] dividend,
    input  logic signed [32:0] divisor,
    output logic               done,
    output logic signed [48:0] quotient
);
    import cii_pkg::*;

    logic [47:0] rem_q_reg, rem_q_next;   // shifting quotient
    logic [32:0] rem_reg, rem_next;
    logic [32:0] dvs_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;
    logic [47:0] abs_dd;
    logic [32:0] abs_dv;

    // dividend magnitude stays below 2^48
    assign abs_dd = dividend[48] ? 48'(-dividend) : 48'(dividend);
    assign abs_dv = divisor[32] ? 33'(-divisor) : 33'(divisor);
    assign trial  = {rem_reg, rem_q_reg[47]} - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next   = rem_reg;
        rem_q_next = rem_q_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            rem_next   = '0;
            rem_q_next = abs_dd;
            cnt_next   = 6'd48;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next   = trial[32:0];
                rem_q_next = {rem_q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next   = {rem_reg[31:0], rem_q_reg[47]};
                rem_q_next = {rem_q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done     <= busy_reg && (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        rem_q_reg <= rem_q_next;
        if (start)
        begin
            dvs_reg <= abs_dv;
            neg_reg <= dividend[48] ^ divisor[32];
        end
    end

    assign quotient = neg_reg ? -$signed({1'b0, rem_q_reg}) : $signed({1'b0, rem_q_reg});

endmodule

/* hw/rtl/cii_engine.sv */
// cii_engine: key memories, min/max scan, segment search and interpolation
// depends on cii_pkg and cii_divider
`timescale 1ns / 1ps

module cii_engine #(
    parameter int MAX_KEYS = cii_pkg::MAX_KEYS_DEFAULT,
    parameter int IW       = $clog2(MAX_KEYS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IW-1:0]        wr_addr,
    input  logic [31:0]          wr_time,
    input  logic [31:0]          wr_value,
    input  logic [6:0]           key_count,
    input  logic                 cmd_valid,
    input  cii_pkg::query_cmd_t  cmd,
    output logic                 cmd_take,
    output logic                 busy,
    output logic                 res_valid,
    output logic signed [31:0]   res_time,
    output logic [1:0]           res_status,
    input  logic                 res_take
);
    import cii_pkg::*;

    logic [31:0] time_mem [MAX_KEYS];
    logic [31:0] value_mem [MAX_KEYS];

    eng_state_t         st_reg, st_next;
    logic [IW:0]        idx_reg, idx_next;
    logic [IW:0]        n_reg;
    logic [IW-1:0]      ra;
    logic signed [31:0] rd_t, rd_v;
    logic signed [31:0] d_reg, mn_reg, mx_reg;
    logic signed [31:0] t0_reg, v0_reg;
    logic signed [32:0] dt_reg;
    logic [15:0]        frac_reg;
    logic signed [49:0] prod_reg;
    logic signed [31:0] out_t_reg;
    logic [1:0]         out_s_reg;
    logic               div_start, div_done;
    logic signed [48:0] div_q;
    logic signed [48:0] num49;
    logic signed [32:0] den33;
    logic signed [49:0] offs;
    logic signed [50:0] tsum;
    logic [IW:0]        nk;

    assign nk = (32'(key_count) > MAX_KEYS) ? (IW+1)'(MAX_KEYS) : (IW+1)'(key_count);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr]  <= wr_time;
            value_mem[wr_addr] <= wr_value;
        end
        rd_t <= time_mem[ra];
        rd_v <= value_mem[ra];
    end

    assign num49 = (49'(d_reg) - 49'(v0_reg)) <<< 16;
    assign den33 = 33'(rd_v) - 33'(v0_reg);

    cii_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num49),
        .divisor  (den33),
        .done     (div_done),
        .quotient (div_q)
    );

    assign offs = prod_reg >>> 16;
    assign tsum = 51'(t0_reg) + 51'(prod_reg[49] ? -((-prod_reg) >>> 16) : offs);

    always_comb
    begin
        st_next   = st_reg;
        idx_next  = idx_reg;
        ra        = idx_reg[IW-1:0];
        cmd_take  = 1'b0;
        div_start = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    idx_next = '0;
                    ra       = '0;
                    st_next  = cmd.few ? ST_OUT : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                idx_next = idx_reg + 1'b1;
                ra       = IW'(idx_reg + 1'b1);
                st_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == n_reg)
                begin
                    ra      = IW'(n_reg - 1'b1);
                    st_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    ra       = IW'(idx_reg + 1'b1);
                end
            end
            ST_DECIDE:
            begin
                // read port now holds key n-1; key 0 is fetched for the low clamp
                ra = '0;
                if (d_reg >= mx_reg)
                    st_next = ST_OUT;
                else if (d_reg < mn_reg)
                    st_next = ST_CLAMP_LO;
                else
                begin
                    idx_next = (IW+1)'(1);
                    ra       = IW'(1);
                    st_next  = ST_FIND;
                end
            end
            ST_CLAMP_LO:
                st_next = ST_OUT;
            ST_FIND:
            begin
                // key idx_reg is on the read port
                if (idx_reg == n_reg)
                    st_next = ST_OUT;
                else if (rd_v > d_reg)
                begin
                    ra      = IW'(idx_reg - 1'b1);
                    st_next = ST_SEG_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    ra       = IW'(idx_reg + 1'b1);
                end
            end
            ST_SEG_RD:
            begin
                ra      = IW'(idx_reg);
                st_next = ST_SEG_LATCH;
            end
            ST_SEG_LATCH:
            begin
                div_start = (den33 != '0);
                st_next   = (den33 != '0) ? ST_DIV : ST_MUL;
            end
            ST_DIV:
            begin
                if (div_done)
                    st_next = ST_MUL;
            end
            ST_MUL:
                st_next = ST_SUM;
            ST_SUM:
                st_next = ST_OUT;
            ST_OUT:
            begin
                if (res_take)
                    st_next = ST_IDLE;
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
        end
    end

    // memories are in use from the scan until the result is formed
    assign busy       = (st_reg != ST_IDLE) && (st_reg != ST_OUT);
    assign res_valid  = (st_reg == ST_OUT);
    assign res_time   = out_t_reg;
    assign res_status = out_s_reg;

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                d_reg     <= cmd.distance;
                n_reg     <= nk;
                out_t_reg <= '0;
                out_s_reg <= STATUS_FEW_KEYS;
            end
            ST_SCAN_RD:
            begin
                // key 0 is on the read port
                mn_reg <= rd_v;
                mx_reg <= rd_v;
            end
            ST_SCAN:
            begin
                if (idx_reg != n_reg)
                begin
                    if (rd_v < mn_reg) mn_reg <= rd_v;
                    if (rd_v > mx_reg) mx_reg <= rd_v;
                end
            end
            ST_DECIDE:
            begin
                if (d_reg >= mx_reg)
                begin
                    out_t_reg <= rd_t;
                    out_s_reg <= STATUS_CLAMP_HI;
                end
            end
            ST_CLAMP_LO:
            begin
                out_t_reg <= rd_t;
                out_s_reg <= STATUS_CLAMP_LO;
            end
            ST_SEG_RD:
            begin
                t0_reg <= rd_t;
                v0_reg <= rd_v;
            end
            ST_SEG_LATCH:
            begin
                dt_reg   <= 33'(rd_t) - 33'(t0_reg);
                frac_reg <= '0;
            end
            ST_DIV:
            begin
                if (div_done)
                    frac_reg <= (div_q < 0) ? 16'd0 :
                                (div_q > 49'sd65535) ? 16'hffff : div_q[15:0];
            end
            ST_MUL:
                prod_reg <= 50'(dt_reg) * $signed({1'b0, frac_reg});
            ST_SUM:
            begin
                out_t_reg <= (tsum > 51'sd2147483647) ? 32'sh7fffffff :
                             (tsum < -51'sd2147483648) ? 32'sh80000000 : 32'(tsum);
                out_s_reg <= STATUS_INTERP;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* verif/curve_inverse_interpolator_tb.sv */
// curve_inverse_interpolator_tb: self-checking bench for the curve inverse interpolator
// drives loads, queries and key_count writes, predicts each answer and checks it
// depends on cii_pkg and curve_inverse_interpolator
`timescale 1ns / 1ps

module curve_inverse_interpolator_tb;
    import cii_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    // settle time before a key_count write
    localparam int SETTLE_CYCLES  = 400;

    typedef struct {
        logic signed [31:0] start_time;
        logic [1:0]         status;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               op = OP_LOAD;
    logic [5:0]         key_index = '0;
    logic signed [31:0] key_time = '0;
    logic signed [31:0] key_value = '0;
    logic signed [31:0] query_distance = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] start_time;
    logic [1:0]         status;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [6:0]         cfg_data = '0;

    // shadow copy of the curve table and key_count
    logic signed [31:0] shadow_time [64];
    logic signed [31:0] shadow_value [64];
    logic [6:0]         shadow_count;

    answer_t            pending_answers [$];
    int                 error_count;
    int                 load_count;
    int                 query_count;
    int                 status_seen [4];
    int                 idle_cycles;
    bit                 quiet;          // no idling on either side
    int                 hold_request;   // receiver hold-off in cycles
    bit                 any_accept;

    always #1 clk = ~clk;

    curve_inverse_interpolator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .key_index      (key_index),
        .key_time       (key_time),
        .key_value      (key_value),
        .query_distance (query_distance),
        .empty          (empty),
        .pop            (pop),
        .start_time     (start_time),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // expected time for a distance over the current shadow curve
    function automatic answer_t invert_curve(input logic signed [31:0] qdist);
        answer_t ans;
        int      n;
        int      x;
        longint  d;
        longint  lo;
        longint  hi;
        longint  num;
        longint  den;
        longint  dt;
        longint  frac;
        longint  t;
        ans.start_time = '0;
        ans.status = STATUS_FEW_KEYS;
        n = (shadow_count > 64) ? 64 : int'(shadow_count);
        d = qdist;
        if (n < 2)
        begin
            return ans;
        end
        lo = shadow_value[0];
        hi = lo;
        for (int i = 1; i < n; i++)
        begin
            if (shadow_value[i] < lo) lo = shadow_value[i];
            if (shadow_value[i] > hi) hi = shadow_value[i];
        end
        if (d >= hi)
        begin
            ans.start_time = shadow_time[n-1];
            ans.status = STATUS_CLAMP_HI;
            return ans;
        end
        if (d < lo)
        begin
            ans.start_time = shadow_time[0];
            ans.status = STATUS_CLAMP_LO;
            return ans;
        end
        // first key from index 1 that lies above the distance
        x = 1;
        while (x < n && !(longint'(shadow_value[x]) > d))
            x++;
        if (x >= n)
        begin
            return ans;
        end
        num = d - longint'(shadow_value[x-1]);
        den = longint'(shadow_value[x]) - longint'(shadow_value[x-1]);
        dt = longint'(shadow_time[x]) - longint'(shadow_time[x-1]);
        frac = (den == 0) ? 0 : (num * 65536) / den;
        if (frac < 0) frac = 0;
        if (frac > 65535) frac = 65535;
        t = longint'(shadow_time[x-1]) + (dt * frac) / 65536;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        ans.start_time = t[31:0];
        ans.status = STATUS_INTERP;
        return ans;
    endfunction

    // offer one item and hold push until the block takes it; push stays high on return
    task automatic send_item(input logic o, input logic [5:0] idx, input logic [31:0] t,
                             input logic [31:0] v, input logic [31:0] d);
        op <= o;
        key_index <= idx;
        key_time <= t;
        key_value <= v;
        query_distance <= d;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (o == OP_LOAD)
        begin
            shadow_time[idx] = t;
            shadow_value[idx] = v;
            load_count++;
        end
        else
        begin
            pending_answers.push_back(invert_curve(d));
            query_count++;
        end
    endtask

    // sender gap after an item, in random bursts
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic load_key(input logic [5:0] idx, input logic [31:0] t, input logic [31:0] v);
        send_item(OP_LOAD, idx, t, v, $urandom);
        sender_gap();
    endtask

    task automatic ask_distance(input logic [31:0] d);
        send_item(OP_QUERY, 6'($urandom), $urandom, $urandom, d);
        sender_gap();
    endtask

    // write key_count once every answer is back and the engine has settled
    task automatic write_key_count(input logic [6:0] n);
        push <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_count = n;
    endtask

    // rising curve over the first n entries starting at a random point
    task automatic load_rising_curve(input int n);
        logic signed [31:0] v;
        logic signed [31:0] t;
        v = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
        t = $urandom;
        for (int i = 0; i < n; i++)
        begin
            load_key(6'(i), t, v);
            v = v + $urandom_range(0, 32'h0020_0000);
            t = t + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0010_0000;
        end
    endtask

    // distance close to a stored value or between neighbors, fully random, or an extreme
    function automatic logic [31:0] pick_distance();
        int k;
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return shadow_value[k];
            2: return shadow_value[k] + $signed($urandom_range(0, 8)) - 4;
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return shadow_value[k] + $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    // extremes, every op, every clamp and the few-keys, no-segment cases
    task automatic test_directed();
        for (int i = 0; i < 64; i++)
            shadow_time[i] = 'x;
        // fill every entry so no query ever reads an unwritten key
        for (int i = 0; i < 64; i++)
            load_key(6'(i), i * 32'h0001_0000, i * 32'h0002_0000);
        ask_distance(32'h0001_0000);            // key_count 0: too few keys
        write_key_count(7'd1);
        ask_distance(32'h0000_0000);
        write_key_count(7'd2);
        ask_distance(32'h0001_0000);            // interpolated halfway
        ask_distance(32'h0002_0000);            // exactly at maximum
        ask_distance(32'h7fff_ffff);
        ask_distance(32'h8000_0000);
        ask_distance(32'hffff_ffff);            // just below minimum
        ask_distance(32'h0000_0000);            // at minimum
        // extreme times and values stretch the interpolated result over the full range
        load_key(0, 32'h8000_0000, 32'h8000_0000);
        load_key(1, 32'h7fff_ffff, 32'h7fff_ffff);
        ask_distance(32'h7fff_fffe);
        ask_distance(32'h0000_0000);
        // falling pair: maximum at key 0, no key above the distance
        load_key(0, 32'h0003_0000, 32'h000a_0000);
        load_key(1, 32'h0005_0000, 32'h0000_0000);
        ask_distance(32'h0005_0000);
        write_key_count(7'd127);                // treated as the full table
        ask_distance(32'h0010_0000);
        ask_distance(32'h7fff_ffff);
        write_key_count(7'd64);
        ask_distance(32'h0040_0001);
    endtask

    // settings of key_count with rising curves, random loads and noisy queries
    task automatic test_random_phases();
        int n;
        for (int phase = 0; phase < 9; phase++)
        begin
            quiet = (phase == 8);
            case (phase)
                0: n = 0;
                1: n = 1;
                2: n = 2;
                3: n = 64;
                4: n = 127;
                5: n = 3;
                default: n = $urandom_range(2, 100);
            endcase
            write_key_count(7'(n));
            if ($urandom_range(0, 3) != 0)
                load_rising_curve(n > 64 ? 64 : n);
            for (int k = 0; k < 55; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    load_key(6'($urandom), $urandom, ($urandom_range(0, 1)) ?
                             $urandom : shadow_value[$urandom_range(0, 63)]);
                else
                    ask_distance(pick_distance());
            end
        end
    endtask

    // receiver holds off while queries pile up and the input stalls
    task automatic test_backpressure();
        write_key_count(7'd8);
        hold_request = 600;
        for (int k = 0; k < 12; k++)
            send_item(OP_QUERY, '0, '0, '0, pick_distance());
        push <= 1'b0;
    endtask

    // receiver: random pop bursts plus a requested long hold-off
    int stall_left;
    initial
    begin
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                pop <= 1'b0;
                hold_request--;
            end
            else
            begin
                if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 16);
                if (stall_left > 0)
                begin
                    pop <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    pop <= 1'b1;
                end
            end
        end
    end

    // answer checker
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected answer time %h status %0d",
                                          start_time, status));
            end
            else
            begin
                want = pending_answers.pop_front();
                status_seen[want.status]++;
                if (start_time !== want.start_time)
                    report_mismatch($sformatf("start_time %h, want %h",
                                              start_time, want.start_time));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        any_accept = (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready);
        if (!rst_n || any_accept)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d answers pending", pending_answers.size());
            $display("[curve_inverse_interpolator] ERROR");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        load_count = 0;
        query_count = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_request = 0;
        shadow_count = '0;
        for (int s = 0; s < 4; s++)
            status_seen[s] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_phases();
        push <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d key loads and %0d queries over key_count settings 0..127",
                 load_count, query_count);
        $display("answers: %0d interpolated, %0d clamped high, %0d clamped low, %0d no result",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("[curve_inverse_interpolator] OK");
        else
            $display("[curve_inverse_interpolator] ERROR");
        $finish;
    end

endmodule
